// File: hw/rtl/apsp_pkg.sv
// Shared types and constants for the aged priority slot picker.
package apsp_pkg;

    localparam int FUNC_W  = 3;
    localparam int SLOT_W  = 4;
    localparam int PRIO_W  = 16;
    localparam int SCORE_W = 17;

    typedef enum logic [FUNC_W-1:0] {
        FN_REGISTER   = 3'd0,
        FN_UNREGISTER = 3'd1,
        FN_PICK       = 3'd2,
        FN_REPORT     = 3'd3,
        FN_NEWBATCH   = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REG,
        S_PICK,
        S_PICK_END,
        S_UPDATE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, rewind scan index, clear best
        logic inc_idx;    // advance scan index
        logic pick_rd;    // read slot entry at scan index
        logic reg_try;    // claim slot at scan index if free
        logic upd;        // apply unregister / report / new batch
        logic emit_pick;  // publish pick result
        logic emit_zero;  // publish all-zero result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cur_free;
        logic idx_last;
    } t_dp_sts;

endpackage

// File: hw/rtl/apsp_ctrl.sv
// Sequencing state machine for the aged priority slot picker.
module apsp_ctrl
    import apsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [FUNC_W-1:0] i_func,
    input  t_dp_sts           i_sts,
    output t_dp_cmd           o_cmd,
    output logic              o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (t_func'(i_func))
                        FN_REGISTER: n_state = S_REG;
                        FN_PICK:     n_state = S_PICK;
                        default:     n_state = S_UPDATE;
                    endcase
                end
            end
            S_REG: begin
                o_cmd.reg_try = 1'b1;
                if (i_sts.cur_free) begin
                    n_state = S_IDLE;  // datapath publishes the claimed slot
                end else if (i_sts.idx_last) begin
                    o_cmd.emit_zero = 1'b1;  // table full
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_PICK: begin
                o_cmd.pick_rd = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_PICK_END;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_PICK_END: begin
                o_cmd.emit_pick = 1'b1;  // last entry drains this cycle
                n_state         = S_IDLE;
            end
            S_UPDATE: begin
                o_cmd.upd       = 1'b1;
                o_cmd.emit_zero = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/apsp_dp.sv
// Slot table, aging/scoring pipeline and result register.
module apsp_dp
    import apsp_pkg::*;
#(
    parameter int NUM_SLOTS  = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [PRIO_W-1:0]  i_base_priority,
    input  logic [PRIO_W-1:0]  i_age_step,
    output logic               o_valid,
    output logic               o_ok,
    output logic [SLOT_W-1:0]  o_granted_slot,
    output logic [SCORE_W-1:0] o_winning_score
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int VB = VALUE_BITS;

    // entry contents; an entry that is not valid reads as zero
    logic [VB-1:0] mem_base [NUM_SLOTS];
    logic [VB-1:0] mem_step [NUM_SLOTS];
    logic [VB-1:0] mem_age  [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] r_valid;
    logic [NUM_SLOTS-1:0] r_served;

    // latched request
    logic [FUNC_W-1:0] r_func;
    logic [SLOT_W-1:0] r_slot;
    logic [VB-1:0]     r_bp;
    logic [VB-1:0]     r_step;

    logic [IW-1:0] r_idx;

    // read stage
    logic          r_rd_v;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_live;
    logic          r_rd_elig;
    logic [VB-1:0] r_rd_base;
    logic [VB-1:0] r_rd_step;
    logic [VB-1:0] r_rd_age;

    // running best
    logic          r_found;
    logic [IW-1:0] r_who;
    logic [VB:0]   r_best;
    logic          n_found;
    logic [IW-1:0] n_who;
    logic [VB:0]   n_best;

    logic          r_out_v;
    logic          r_ok;
    logic [IW-1:0] r_out_slot;
    logic [VB:0]   r_out_score;

    logic [VB-1:0] p_base;
    logic [VB-1:0] p_step;
    logic [VB-1:0] p_age;
    logic [VB:0]   age_sum;
    logic [VB-1:0] age_new;
    logic [VB:0]   score;

    logic [IW-1:0] req_idx;
    logic          req_in_range;
    logic          reg_hit;

    logic          age_we;
    logic [IW-1:0] age_wa;
    logic [VB-1:0] age_wd;

    assign req_idx      = IW'(r_slot);
    assign req_in_range = 32'(r_slot) < NUM_SLOTS;
    assign reg_hit      = i_cmd.reg_try && !r_valid[r_idx];

    assign o_sts.cur_free = !r_valid[r_idx];
    assign o_sts.idx_last = (r_idx == IW'(NUM_SLOTS - 1));

    // aging and scoring of the entry read last cycle
    always_comb begin
        p_base  = r_rd_live ? r_rd_base : '0;
        p_step  = r_rd_live ? r_rd_step : '0;
        p_age   = r_rd_live ? r_rd_age  : '0;
        age_sum = {1'b0, p_age} + {1'b0, p_step};
        age_new = age_sum[VB] ? {VB{1'b1}} : age_sum[VB-1:0];
        score   = {1'b0, age_new} + {1'b0, p_base};
        n_found = r_found;
        n_who   = r_who;
        n_best  = r_best;
        if (r_rd_v && r_rd_elig && (score > r_best)) begin
            n_found = 1'b1;
            n_who   = r_rd_idx;
            n_best  = score;
        end
    end

    // age write port
    always_comb begin
        age_we = 1'b0;
        age_wa = r_rd_idx;
        age_wd = age_new;
        if (r_rd_v) begin
            age_we = 1'b1;
        end else if (reg_hit) begin
            age_we = 1'b1;
            age_wa = r_idx;
            age_wd = '0;
        end else if (i_cmd.upd && t_func'(r_func) == FN_REPORT && req_in_range
                     && r_valid[req_idx]) begin
            age_we = 1'b1;
            age_wa = req_idx;
            age_wd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (reg_hit) begin
            mem_base[r_idx] <= r_bp;
            mem_step[r_idx] <= r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (age_we) begin
            mem_age[age_wa] <= age_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick_rd) begin
            r_rd_base <= mem_base[r_idx];
            r_rd_step <= mem_step[r_idx];
            r_rd_age  <= mem_age[r_idx];
            r_rd_idx  <= r_idx;
            r_rd_live <= r_valid[r_idx];
            r_rd_elig <= r_valid[r_idx] && !r_served[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_slot <= i_slot;
            r_bp   <= VB'(i_base_priority);
            r_step <= VB'(i_age_step);
        end
        if (i_cmd.load) begin
            r_best <= '0;
            r_who  <= '0;
        end else begin
            r_best <= n_best;
            r_who  <= n_who;
        end
        if (reg_hit) begin
            r_out_slot  <= r_idx;
            r_out_score <= '0;
        end else if (i_cmd.emit_pick) begin
            r_out_slot  <= n_found ? n_who  : '0;
            r_out_score <= n_found ? n_best : '0;
        end else if (i_cmd.emit_zero) begin
            r_out_slot  <= '0;
            r_out_score <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_served <= '0;
            r_idx    <= '0;
            r_rd_v   <= 1'b0;
            r_found  <= 1'b0;
            r_out_v  <= 1'b0;
            r_ok     <= 1'b0;
        end else begin
            r_rd_v  <= i_cmd.pick_rd;
            r_out_v <= reg_hit || i_cmd.emit_pick || i_cmd.emit_zero;
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else begin
                r_found <= n_found;
                if (i_cmd.inc_idx) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (reg_hit) begin
                r_ok <= 1'b1;
            end else if (i_cmd.emit_pick) begin
                r_ok <= n_found;
            end else if (i_cmd.emit_zero) begin
                r_ok <= 1'b0;
            end
            if (reg_hit) begin
                r_valid[r_idx]  <= 1'b1;
                r_served[r_idx] <= 1'b0;
            end
            if (i_cmd.upd) begin
                case (t_func'(r_func))
                    FN_UNREGISTER: begin
                        if (req_in_range) begin
                            r_valid[req_idx]  <= 1'b0;
                            r_served[req_idx] <= 1'b0;
                        end
                    end
                    FN_REPORT: begin
                        if (req_in_range && r_valid[req_idx]) begin
                            r_served[req_idx] <= 1'b1;
                        end
                    end
                    FN_NEWBATCH: begin
                        r_served <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_valid         = r_out_v;
    assign o_ok            = r_ok;
    assign o_granted_slot  = SLOT_W'(r_out_slot);
    assign o_winning_score = SCORE_W'(r_out_score);

endmodule

// File: hw/rtl/aged_priority_slot_picker_top.sv
// Pick scans the whole table; register scans for the first free slot and stops
// there; other functions update the table without a scan.
// A new request is taken the cycle o_valid rises. The slot scan reads one entry
// per cycle through the single table read port.
// Result is a one-cycle strobe on o_valid; the receiver cannot stall it.
// Synchronous active-low reset empties the table; no clearing pass is needed.
module aged_priority_slot_picker_top
    import apsp_pkg::*;
#(
    parameter int NUM_SLOTS  = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [PRIO_W-1:0]  i_base_priority,
    input  logic [PRIO_W-1:0]  i_age_step,
    output logic               o_valid,
    output logic               o_ok,
    output logic [SLOT_W-1:0]  o_granted_slot,
    output logic [SCORE_W-1:0] o_winning_score
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    apsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    apsp_dp #(
        .NUM_SLOTS  (NUM_SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_func          (i_func),
        .i_slot          (i_slot),
        .i_base_priority (i_base_priority),
        .i_age_step      (i_age_step),
        .o_valid         (o_valid),
        .o_ok            (o_ok),
        .o_granted_slot  (o_granted_slot),
        .o_winning_score (o_winning_score)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_no_ok_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_granted_slot == '0 && o_winning_score == '0))
        else $error("failed request carries nonzero fields");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_strobe_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

endmodule
